@@ rtl/cdrs_pkg.sv @@
// ----------------------------------------------------------------------------
// CDR stream serializer package
// Shared types, command codes and constants for the serializer block.
// ----------------------------------------------------------------------------
package cdrs_pkg;

  // Width of the write position and alignment origin
  localparam int POS_BITS = 16;
  // Width of the capacity register and of the reported length
  localparam int CAP_BITS = 16;
  localparam int LEN_BITS = 16;
  // Compare width wide enough for position plus chunk and for capacity
  localparam int CMP_W = ((POS_BITS + 1) > (CAP_BITS + 1)) ? (POS_BITS + 1) : (CAP_BITS + 1);
  // Byte counters hold at most eight bytes per chunk
  localparam int CNT_BITS = 4;

  localparam logic [CAP_BITS-1:0] CAPACITY_RESET = '1;
  // Encapsulation header 00 01 00 00, packed so the first byte is lowest
  localparam logic [63:0] HDR_WORD = 64'h0000_0000_0000_0100;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_HEADER = 3'd1,
    CMD_BYTE   = 3'd2,
    CMD_WORD32 = 3'd3,
    CMD_WORD64 = 3'd4,
    CMD_FINISH = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_PAD_CHK,
    ST_DATA_CHK,
    ST_EMIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                is_report;
    logic [LEN_BITS-1:0] total_length;
    logic                healthy;
    logic                last;
  } rsp_t;

  // Data length in bytes of a write command
  function automatic logic [CNT_BITS-1:0] cmd_len(input logic [2:0] cmd);
    logic [CNT_BITS-1:0] len;
    unique case (cmd) inside
      CMD_HEADER, CMD_WORD32: len = CNT_BITS'(4);
      CMD_BYTE:               len = CNT_BITS'(1);
      CMD_WORD64:             len = CNT_BITS'(8);
      default:                len = '0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/cdr_le_stream_serializer_top.sv @@
// ----------------------------------------------------------------------------
// Little-endian CDR stream serializer
// Turns typed write requests into a CDR byte stream, one byte per response.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): one command per request,
//   begin, header, byte, aligned word32, aligned word64 or finish. req_stall
//   is high while a request is being worked on; the block takes one request
//   at a time.
//   Response channel (rsp_valid / rsp_stall / rsp): one response per stream
//   byte (zero pad or data, little-endian), or one length report for finish.
//   rsp.last marks the final response of a request; healthy is the ok flag
//   as it stands after the whole request.
//   Configuration (cfg_valid / cfg_ready / cfg_data): writes capacity; write
//   only while the block is idle. cfg_ready is always high.
// Sequencing:
//   A write command is accepted in idle, then passes through align, pad
//   check and data check, the two checks reusing one add-and-compare
//   unit, then emits one byte per cycle while the response slot is free,
//   at most seven pad bytes and a word64; if nothing fits it goes back to
//   idle from data check. Begin and unused codes stay idle; finish uses report.
// Reset:
//   rst clears position and origin, sets ok and restores capacity to 65535.
// Back-pressure:
//   A stalled response holds in the output register; byte emission waits
//   for it to drain. A new request is taken while the last response waits.
// ----------------------------------------------------------------------------
module cdr_le_stream_serializer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  cdrs_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output cdrs_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdrs_pkg::CAP_BITS-1:0] cfg_data
);
  import cdrs_pkg::*;

  state_t              state, state_next;
  logic [CAP_BITS-1:0] capacity;
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] origin;
  logic                ok;
  logic [2:0]          cmd_q;
  logic [63:0]         data_sr;
  logic [CNT_BITS-1:0] pad_left;
  logic [CNT_BITS-1:0] data_left;

  // Shared room check
  logic [CNT_BITS-1:0] fu_len;
  logic [POS_BITS-1:0] fu_sum;
  logic                fu_fits;

  // Control from the sequencer
  logic                slot_free;
  logic                load_rsp;
  rsp_t                rsp_next;
  logic                emit_last;

  // Alignment
  logic [2:0]          rel_lo;
  logic [2:0]          rem;
  logic [CNT_BITS-1:0] align_sz;
  logic [CNT_BITS-1:0] pad_calc;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  // Pad length only for aligned words; low bits of the offset suffice
  always_comb begin
    rel_lo   = (pos >= origin) ? (pos[2:0] - origin[2:0]) : 3'd0;
    rem      = (cmd_q == CMD_WORD32) ? {1'b0, rel_lo[1:0]} : rel_lo;
    align_sz = (cmd_q == CMD_WORD32) ? CNT_BITS'(4) : CNT_BITS'(8);
    if ((cmd_q != CMD_WORD32 && cmd_q != CMD_WORD64) || rem == 3'd0) begin
      pad_calc = '0;
    end else begin
      pad_calc = align_sz - CNT_BITS'(rem);
    end
  end

  // Pad chunk first, then data chunk, against the same unit
  assign fu_len = (state == ST_PAD_CHK) ? pad_left : cmd_len(cmd_q);

  cdrs_fit_unit u_fit (
    .pos      (pos),
    .len      (fu_len),
    .capacity (capacity),
    .ok       (ok),
    .sum      (fu_sum),
    .fits     (fu_fits)
  );

  assign emit_last = (pad_left == CNT_BITS'(0) && data_left == CNT_BITS'(1)) ||
                     (pad_left == CNT_BITS'(1) && data_left == CNT_BITS'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    rsp_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.cmd) inside
            CMD_HEADER, CMD_BYTE, CMD_WORD32, CMD_WORD64: state_next = ST_ALIGN;
            CMD_FINISH:                                   state_next = ST_REPORT;
            default:                                      state_next = ST_IDLE;
          endcase
        end
      end
      ST_ALIGN:   state_next = ST_PAD_CHK;
      ST_PAD_CHK: state_next = ST_DATA_CHK;
      ST_DATA_CHK: begin
        // Nothing to send when both chunks were refused
        state_next = (pad_left != '0 || fu_fits) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_rsp          = 1'b1;
          rsp_next.out_byte = (pad_left != '0) ? 8'h00 : data_sr[7:0];
          rsp_next.healthy  = ok;
          rsp_next.last     = emit_last;
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          load_rsp              = 1'b1;
          rsp_next.is_report    = 1'b1;
          rsp_next.total_length = ok ? LEN_BITS'(pos) : '0;
          rsp_next.healthy      = ok;
          rsp_next.last         = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Message state: position, origin, ok flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      origin <= '0;
      ok     <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid && req.cmd == CMD_BEGIN) begin
            pos    <= '0;
            origin <= '0;
            ok     <= 1'b1;
          end
        end
        ST_PAD_CHK: begin
          if (pad_left != '0) begin
            ok <= fu_fits;
            if (fu_fits) begin
              pos <= fu_sum;
            end
          end
        end
        ST_DATA_CHK: begin
          ok <= fu_fits;
          if (fu_fits) begin
            pos <= fu_sum;
          end
          // Header moves the origin even after a failure
          if (cmd_q == CMD_HEADER) begin
            origin <= fu_fits ? fu_sum : pos;
          end
        end
        default: ;
      endcase
    end
  end

  // Request latch and byte counters
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd_q   <= req.cmd;
          data_sr <= (req.cmd == CMD_HEADER) ? HDR_WORD : req.value;
        end
      end
      ST_ALIGN:   pad_left <= pad_calc;
      ST_PAD_CHK: begin
        if (!fu_fits) begin
          pad_left <= '0;
        end
      end
      ST_DATA_CHK: data_left <= fu_fits ? cmd_len(cmd_q) : '0;
      ST_EMIT: begin
        if (slot_free) begin
          if (pad_left != '0) begin
            pad_left <= pad_left - CNT_BITS'(1);
          end else begin
            data_left <= data_left - CNT_BITS'(1);
            data_sr   <= data_sr >> 8;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/cdrs_fit_unit.sv @@
// ----------------------------------------------------------------------------
// CDR serializer room check
// Shared adder and compare: does a chunk of len bytes fit after the position.
// ----------------------------------------------------------------------------
module cdrs_fit_unit (
  input  logic [cdrs_pkg::POS_BITS-1:0] pos,
  input  logic [cdrs_pkg::CNT_BITS-1:0] len,
  input  logic [cdrs_pkg::CAP_BITS-1:0] capacity,
  input  logic                          ok,
  output logic [cdrs_pkg::POS_BITS-1:0] sum,
  output logic                          fits
);
  import cdrs_pkg::*;

  localparam logic [CMP_W-1:0] POS_MAX = CMP_W'((64'd1 << POS_BITS) - 64'd1);

  logic [CMP_W-1:0] end_pos;

  always_comb begin
    end_pos = CMP_W'(pos) + CMP_W'(len);
    sum     = end_pos[POS_BITS-1:0];
    fits    = ok && (end_pos <= CMP_W'(capacity)) && (end_pos <= POS_MAX);
  end

endmodule

@@ rtl/cdrs_checker.sv @@
// ----------------------------------------------------------------------------
// CDR serializer port checker
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module cdrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input cdrs_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cdrs_pkg::rsp_t rsp
);
  import cdrs_pkg::*;

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Finish report is always the final response
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_report |-> rsp.last)
    else $error("report without last");

  // Byte responses carry no length
  a_byte_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.is_report |-> rsp.total_length == '0)
    else $error("byte response with length");

  // Failed message reports zero length
  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_report && !rsp.healthy |-> rsp.total_length == '0)
    else $error("failed message reported nonzero length");

  // An accepted write request stalls the channel in the following cycle
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall &&
    (req.cmd == CMD_HEADER || req.cmd == CMD_BYTE ||
     req.cmd == CMD_WORD32 || req.cmd == CMD_WORD64) |=> req_stall)
    else $error("write request did not stall the channel");

endmodule

bind cdr_le_stream_serializer_top cdrs_checker u_cdrs_checker (.*);
